// ----- sv/clt_pkg.sv -----
`default_nettype none

package clt_pkg;

    localparam int RECORD_BYTES_DEF = 1024;
    localparam int MAX_TOKENS_DEF   = 64;
    localparam int QUEUE_DEPTH      = 4;
    localparam int EVENTS_PER_ITEM  = 4;

    localparam logic [7:0] COMMENT_CHAR_RST  = 8'd59;
    localparam logic [7:0] CONTINUE_CHAR_RST = 8'd92;
    localparam logic [7:0] CHAR_QUOTE        = 8'h22;
    localparam logic [7:0] CHAR_SPACE        = 8'h20;
    localparam logic [7:0] CHAR_DEL          = 8'h7F;
    localparam logic [7:0] CHAR_NUL          = 8'h00;

    typedef enum logic [1:0] {
        EV_START  = 2'd0,
        EV_BYTE   = 2'd1,
        EV_END    = 2'd2,
        EV_RECORD = 2'd3
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind    kind;
        logic [7:0]  tok_byte;
        logic        tok_kind;
        logic        quoted;
        logic [5:0]  tok_num;
        logic        ovf;
    } t_event;

    typedef struct packed {
        logic [2:0]   cnt;
        t_event [3:0] ev;
    } t_bundle;

    function automatic t_event mk_ev(t_ev_kind kind, logic [7:0] b, logic tk, logic q,
                                     logic [5:0] num, logic ovf);
        t_event e;
        e.kind     = kind;
        e.tok_byte = b;
        e.tok_kind = tk;
        e.quoted   = q;
        e.tok_num  = num;
        e.ovf      = ovf;
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- sv/clt_front.sv -----
`default_nettype none

module clt_front #(
    parameter int RECORD_BYTES = clt_pkg::RECORD_BYTES_DEF,
    parameter int MAX_TOKENS   = clt_pkg::MAX_TOKENS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_char_byte,
    input  wire logic            i_has_byte,
    input  wire logic            i_line_last,
    input  wire logic [7:0]      i_comment_char,
    input  wire logic [7:0]      i_continue_char,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output clt_pkg::t_bundle     o_bundle
);
    import clt_pkg::*;

    localparam int TC_W = $clog2(MAX_TOKENS + 1);
    localparam int BC_W = $clog2(RECORD_BYTES + 1);
    localparam logic [TC_W-1:0] TC_MAX = TC_W'(MAX_TOKENS);
    localparam logic [BC_W-1:0] BC_MAX = BC_W'(RECORD_BYTES);

    typedef enum logic [2:0] {
        M_BETWEEN = 3'd0,
        M_QUOTED  = 3'd1,
        M_WRAP    = 3'd2,
        M_BARE    = 3'd3,
        M_COMMENT = 3'd4,
        M_PENDING = 3'd5
    } t_mode;

    t_mode           r_mode, n_mode;
    logic            r_cs, n_cs;
    logic [TC_W-1:0] r_tc, n_tc;
    logic [BC_W-1:0] r_bc, n_bc;
    logic            r_qhs, n_qhs;
    logic            r_ovf, n_ovf;
    logic            r_td, n_td;
    logic            r_sr, n_sr;
    logic            r_lp, n_lp;
    logic            r_ld, n_ld;

    t_event [3:0]    v_ev;
    logic [2:0]      v_n;
    logic            is_ws;
    logic            is_ctl;
    logic            accept;

    function automatic logic [5:0] num_of(logic [TC_W-1:0] t);
        return (t == '0) ? 6'd0 : 6'(t - TC_W'(1));
    endfunction

    assign is_ws  = (i_char_byte == CHAR_SPACE) ||
                    (i_char_byte >= 8'h09 && i_char_byte <= 8'h0D);
    assign is_ctl = (i_char_byte < CHAR_SPACE) || (i_char_byte == CHAR_DEL);

    always_comb begin
        n_mode = r_mode;
        n_cs   = r_cs;
        n_tc   = r_tc;
        n_bc   = r_bc;
        n_qhs  = r_qhs;
        n_ovf  = r_ovf;
        n_td   = r_td;
        n_sr   = r_sr;
        n_lp   = r_lp;
        n_ld   = r_ld;
        v_ev   = '0;
        v_n    = '0;

        if (i_has_byte && !r_ld) begin
            if (i_char_byte == CHAR_NUL) begin
                n_ld = 1'b1;
            end else if (is_ws) begin
                n_lp = 1'b0;
                case (n_mode)
                    M_BARE: begin
                        if (!n_td) begin
                            v_ev[v_n[1:0]] = mk_ev(EV_END, 8'h00, 1'b0, n_qhs,
                                                   num_of(n_tc), 1'b0);
                            v_n = v_n + 3'd1;
                        end
                        n_mode = M_BETWEEN;
                        if (!n_sr) begin
                            if (n_bc < BC_MAX) n_bc = n_bc + BC_W'(1);
                            else n_ovf = 1'b1;
                        end
                        n_sr = 1'b1;
                    end
                    M_QUOTED, M_COMMENT: begin
                        if (n_mode == M_QUOTED) n_qhs = 1'b1;
                        if (n_bc < BC_MAX) begin
                            n_bc = n_bc + BC_W'(1);
                            if (!n_td) begin
                                v_ev[v_n[1:0]] = mk_ev(EV_BYTE, CHAR_SPACE,
                                                       n_mode == M_COMMENT, 1'b0,
                                                       num_of(n_tc), 1'b0);
                                v_n = v_n + 3'd1;
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    M_WRAP, M_PENDING: begin
                    end
                    default: begin
                        if (!n_sr) begin
                            if (n_bc < BC_MAX) n_bc = n_bc + BC_W'(1);
                            else n_ovf = 1'b1;
                        end
                        n_sr = 1'b1;
                    end
                endcase
            end else begin
                n_sr = 1'b0;
                if (n_mode == M_PENDING) begin
                    n_mode = M_COMMENT;
                    n_qhs  = 1'b0;
                    if (n_tc < TC_MAX) begin
                        n_td = 1'b0;
                        v_ev[v_n[1:0]] = mk_ev(EV_START, 8'h00, 1'b1, 1'b0, 6'(n_tc), 1'b0);
                        v_n  = v_n + 3'd1;
                        n_tc = n_tc + TC_W'(1);
                    end else begin
                        n_td  = 1'b1;
                        n_ovf = 1'b1;
                    end
                end
                if (is_ctl) begin
                    n_lp = 1'b0;
                end else begin
                    n_lp = 1'b1;
                    if (i_char_byte == i_comment_char && n_mode == M_BETWEEN) begin
                        if (n_bc < BC_MAX) n_bc = n_bc + BC_W'(1);
                        else n_ovf = 1'b1;
                        n_mode = M_PENDING;
                    end else if (i_char_byte == CHAR_QUOTE) begin
                        if (n_mode == M_QUOTED || n_mode == M_WRAP) begin
                            if (!n_td) begin
                                v_ev[v_n[1:0]] = mk_ev(EV_END, 8'h00, 1'b0, n_qhs,
                                                       num_of(n_tc), 1'b0);
                                v_n = v_n + 3'd1;
                            end
                            n_mode = M_BETWEEN;
                        end else if (n_mode == M_COMMENT) begin
                            if (n_bc < BC_MAX) begin
                                n_bc = n_bc + BC_W'(1);
                                if (!n_td) begin
                                    v_ev[v_n[1:0]] = mk_ev(EV_BYTE, i_char_byte, 1'b1,
                                                           1'b0, num_of(n_tc), 1'b0);
                                    v_n = v_n + 3'd1;
                                end
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            if (n_mode == M_BARE) begin
                                if (!n_td) begin
                                    v_ev[v_n[1:0]] = mk_ev(EV_END, 8'h00, 1'b0, n_qhs,
                                                           num_of(n_tc), 1'b0);
                                    v_n = v_n + 3'd1;
                                end
                                if (n_bc < BC_MAX) n_bc = n_bc + BC_W'(1);
                                else n_ovf = 1'b1;
                            end
                            n_mode = M_QUOTED;
                            n_qhs  = 1'b0;
                            if (n_tc < TC_MAX) begin
                                n_td = 1'b0;
                                v_ev[v_n[1:0]] = mk_ev(EV_START, 8'h00, 1'b0, 1'b0,
                                                       6'(n_tc), 1'b0);
                                v_n  = v_n + 3'd1;
                                n_tc = n_tc + TC_W'(1);
                            end else begin
                                n_td  = 1'b1;
                                n_ovf = 1'b1;
                            end
                        end
                    end else if (i_char_byte == i_continue_char) begin
                        n_cs = 1'b1;
                    end else begin
                        if (n_mode == M_BETWEEN) begin
                            n_mode = M_BARE;
                            n_qhs  = 1'b0;
                            if (n_tc < TC_MAX) begin
                                n_td = 1'b0;
                                v_ev[v_n[1:0]] = mk_ev(EV_START, 8'h00, 1'b0, 1'b0,
                                                       6'(n_tc), 1'b0);
                                v_n  = v_n + 3'd1;
                                n_tc = n_tc + TC_W'(1);
                            end else begin
                                n_td  = 1'b1;
                                n_ovf = 1'b1;
                            end
                        end else if (n_mode == M_WRAP) begin
                            n_mode = M_QUOTED;
                        end
                        if (n_bc < BC_MAX) begin
                            n_bc = n_bc + BC_W'(1);
                            if (!n_td) begin
                                v_ev[v_n[1:0]] = mk_ev(EV_BYTE, i_char_byte,
                                                       n_mode == M_COMMENT, 1'b0,
                                                       num_of(n_tc), 1'b0);
                                v_n = v_n + 3'd1;
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
        end

        if (i_line_last || !i_has_byte) begin
            if (n_lp) begin
                if (n_mode == M_BARE) begin
                    if (!n_td) begin
                        v_ev[v_n[1:0]] = mk_ev(EV_END, 8'h00, 1'b0, n_qhs,
                                               num_of(n_tc), 1'b0);
                        v_n = v_n + 3'd1;
                    end
                    n_mode = M_BETWEEN;
                end else if (n_mode == M_QUOTED) begin
                    n_mode = M_WRAP;
                end
            end
            if (n_mode == M_PENDING) n_mode = M_BETWEEN;
            if (!n_cs && n_bc != '0 && n_tc != '0) begin
                if (n_mode != M_BETWEEN && !n_td) begin
                    v_ev[v_n[1:0]] = mk_ev(EV_END, 8'h00, n_mode == M_COMMENT,
                                           (n_mode != M_COMMENT) && n_qhs,
                                           num_of(n_tc), 1'b0);
                    v_n = v_n + 3'd1;
                end
                v_ev[v_n[1:0]] = mk_ev(EV_RECORD, 8'h00, 1'b0, 1'b0, 6'd0, n_ovf);
                v_n    = v_n + 3'd1;
                n_mode = M_BETWEEN;
                n_tc   = '0;
                n_bc   = '0;
                n_qhs  = 1'b0;
                n_ovf  = 1'b0;
                n_td   = 1'b0;
            end
            n_cs = 1'b0;
            n_lp = 1'b0;
            n_ld = 1'b0;
            n_sr = 1'b0;
        end
    end

    assign o_ready      = !i_q_full;
    assign accept       = i_valid && !i_q_full;
    assign o_push       = accept && (v_n != '0);
    assign o_bundle.cnt = v_n;
    assign o_bundle.ev  = v_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
            r_cs   <= 1'b0;
            r_tc   <= '0;
            r_bc   <= '0;
            r_qhs  <= 1'b0;
            r_ovf  <= 1'b0;
            r_td   <= 1'b0;
            r_sr   <= 1'b0;
            r_lp   <= 1'b0;
            r_ld   <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_cs   <= n_cs;
            r_tc   <= n_tc;
            r_bc   <= n_bc;
            r_qhs  <= n_qhs;
            r_ovf  <= n_ovf;
            r_td   <= n_td;
            r_sr   <= n_sr;
            r_lp   <= n_lp;
            r_ld   <= n_ld;
        end
    end

endmodule

`default_nettype wire

// ----- sv/clt_queue.sv -----
`default_nettype none

module clt_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire clt_pkg::t_bundle  i_bundle,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output clt_pkg::t_bundle       o_head
);
    import clt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bundle          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PTR_W'(1);
            if (do_pop)  r_rp <= r_rp + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/clt_back.sv -----
`default_nettype none

module clt_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire clt_pkg::t_bundle  i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output clt_pkg::t_event        o_event
);
    import clt_pkg::*;

    logic [1:0] r_sub;
    logic       r_valid;
    t_event     r_ev;
    logic       load;
    logic       last_ev;

    assign load    = !i_empty && (!r_valid || i_ready);
    assign last_ev = ({1'b0, r_sub} + 3'd1) == i_head.cnt;
    assign o_pop   = load && last_ev;
    assign o_valid = r_valid;
    assign o_event = r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= last_ev ? 2'd0 : r_sub + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_ev <= i_head.ev[r_sub];
    end

endmodule

`default_nettype wire

// ----- sv/command_line_tokenizer_unit.sv -----
// Command line tokenizer.
// Slave stream: one line byte per transfer. s_tdata carries the byte,
// s_tuser is 1 for a byte and 0 for an empty-line marker, s_tlast ends a line.
// Master stream: token events (start, byte, end, record end), one per transfer.
// APB port: comment character at 0x0, continuation character at 0x4.
// The front end classifies one input byte per cycle and produces up to four
// events, which go as one entry into a four-entry queue. The back end sends
// them out one per cycle through an output register while the receiver is
// ready, so an item is taken every cycle while the queue has room; sustained
// rate is one event per cycle, set by the single output register. The first
// event of a transfer passes through the queue entry and the output register.
// When the receiver stalls, events collect in the queue and s_tready drops
// once all four entries are taken. Reset clears the scanner state, the queue
// and the output stage and restores the default comment and continuation
// characters.
`default_nettype none

module command_line_tokenizer_unit #(
    parameter int RECORD_BYTES = clt_pkg::RECORD_BYTES_DEF,
    parameter int MAX_TOKENS   = clt_pkg::MAX_TOKENS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tuser,   // [0] has_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] token_byte, [8] quoted_flag,
                                        // [14:9] token_number, [15] overflowed
    output logic [2:0]       m_tuser,   // [1:0] event_kind, [2] token_kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import clt_pkg::*;

    logic       [7:0] r_comment_char;
    logic       [7:0] r_continue_char;
    logic             q_push;
    logic             q_full;
    t_bundle          fr_bundle;
    t_bundle          q_head;
    logic             q_empty;
    logic             q_pop;
    t_event           out_ev;

    assign pready = 1'b1;
    assign prdata = {24'h0, paddr[2] ? r_continue_char : r_comment_char};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comment_char  <= COMMENT_CHAR_RST;
            r_continue_char <= CONTINUE_CHAR_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_continue_char <= pwdata[7:0];
            else          r_comment_char  <= pwdata[7:0];
        end
    end

    clt_front #(
        .RECORD_BYTES (RECORD_BYTES),
        .MAX_TOKENS   (MAX_TOKENS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_tvalid),
        .o_ready         (s_tready),
        .i_char_byte     (s_tdata),
        .i_has_byte      (s_tuser),
        .i_line_last     (s_tlast),
        .i_comment_char  (r_comment_char),
        .i_continue_char (r_continue_char),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_bundle        (fr_bundle)
    );

    clt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (fr_bundle),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    clt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_event (out_ev)
    );

    assign m_tdata = {out_ev.ovf, out_ev.tok_num, out_ev.quoted, out_ev.tok_byte};
    assign m_tuser = {out_ev.tok_kind, out_ev.kind};

endmodule

`default_nettype wire
